### hdl/tkf_pkg.sv
// ----------------------------------------------------------------------------
// tkf_pkg
// Shared widths, codes, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tkf_pkg;

	localparam int VALUE_W = 32;
	localparam int OCC_W   = 16;
	localparam int TOPK_W  = 5;

	localparam int DEF_TABLE_ENTRIES = 16;
	localparam int DEF_COUNT_BITS    = 16;

	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic add;        // count the accepted value
		logic start;      // latch k and arm the first scan
		logic step;       // examine one table entry
		logic emit;       // load the best entry into the result register
		logic emit_none;  // load the empty report and clear the table
	} cmd_t;

	typedef struct packed {
		logic k_zero;     // finish beat would report nothing
		logic scan_last;  // entry under scan is the last used one
		logic out_free;   // result register can take a beat this cycle
		logic final_pick; // the pick being emitted closes the report
	} sts_t;

endpackage

### hdl/tkf_if.sv
// ----------------------------------------------------------------------------
// tkf_item_if, tkf_result_if
// Valid/ready channels for input items and reported results.
// ----------------------------------------------------------------------------
interface tkf_item_if;
	import tkf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [VALUE_W-1:0] value;
	logic        [TOPK_W-1:0]  top_k;

	modport source (output valid, output kind, output value, output top_k, input ready);
	modport sink (input valid, input kind, input value, input top_k, output ready);
endinterface

interface tkf_result_if;
	import tkf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] frequent_value;
	logic        [OCC_W-1:0]   occurrences;
	logic                      no_item;
	logic                      table_overflowed;
	logic                      last_result;

	modport source (
		output valid, output frequent_value, output occurrences, output no_item,
		output table_overflowed, output last_result, input ready
	);
	modport sink (
		input valid, input frequent_value, input occurrences, input no_item,
		input table_overflowed, input last_result, output ready
	);
endinterface

### hdl/top_k_frequent_values.sv
// ----------------------------------------------------------------------------
// top_k_frequent_values
// Counts distinct 32-bit values in a fixed table and reports the k most
// frequent ones, highest count first, ties to the earliest seen value.
//
//   channel   role   beat carries
//   items     sink   kind, value, top_k
//   results   source frequent_value, occurrences, no_item,
//                    table_overflowed, last_result
//
// An add beat updates the table directly; the table match is done on all entries at once.
// A finish beat walks the used entries once per reported value, then emits
// each pick as the output frees; an empty report emits a single no_item beat.
// Items are taken only while no report is in progress.
// A stalled result holds in the output register and halts the report walk.
// Reset empties the table at once through its valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module top_k_frequent_values #(
	parameter int TABLE_ENTRIES = tkf_pkg::DEF_TABLE_ENTRIES,
	parameter int COUNT_BITS    = tkf_pkg::DEF_COUNT_BITS
) (
	input logic          clk,
	input logic          arst_n,
	tkf_item_if.sink     items,
	tkf_result_if.source results
);
	import tkf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tkf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_kind  (items.kind),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tkf_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.COUNT_BITS    (COUNT_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_value (items.value),
		.in_top_k (items.top_k),
		.cmd      (cmd),
		.sts      (sts),
		.results  (results)
	);

endmodule

### hdl/tkf_ctrl.sv
// ----------------------------------------------------------------------------
// tkf_ctrl
// Sequencer: takes beats while idle, walks the table once per reported
// value, and hands each pick to the result register.
// ----------------------------------------------------------------------------
module tkf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_kind,
	output logic          in_ready,
	input  tkf_pkg::sts_t sts,
	output tkf_pkg::cmd_t cmd
);
	import tkf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_kind == KIND_FINISH) begin
					state_nxt = sts.k_zero ? ST_EMPTY : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_nxt = sts.final_pick ? ST_IDLE : ST_SCAN;
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.add   = in_valid && in_kind == KIND_ADD;
				cmd.start = in_valid && in_kind == KIND_FINISH;
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			ST_EMPTY: begin
				cmd.emit_none = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hdl/tkf_datapath.sv
// ----------------------------------------------------------------------------
// tkf_datapath
// Value/count table with parallel match, report marks, the max-count
// scan registers and the result register.
// ----------------------------------------------------------------------------
module tkf_datapath #(
	parameter int TABLE_ENTRIES = tkf_pkg::DEF_TABLE_ENTRIES,
	parameter int COUNT_BITS    = tkf_pkg::DEF_COUNT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [tkf_pkg::VALUE_W-1:0] in_value,
	input  logic        [tkf_pkg::TOPK_W-1:0]  in_top_k,
	input  tkf_pkg::cmd_t                      cmd,
	output tkf_pkg::sts_t                      sts,
	tkf_result_if.source                       results
);
	import tkf_pkg::*;

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
	localparam int KW     = (USED_W > TOPK_W) ? USED_W : TOPK_W;

	logic [VALUE_W-1:0]    entry_value_q [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] entry_count_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] entry_valid_q;
	logic [TABLE_ENTRIES-1:0] reported_q;
	logic [USED_W-1:0]     used_q;
	logic                  overflow_q;

	logic [IDX_W-1:0]      scan_idx_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [VALUE_W-1:0]    best_value_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic                  best_none_q;
	logic [TOPK_W-1:0]     k_left_q;

	logic                  res_valid_q;
	logic [VALUE_W-1:0]    res_value_q;
	logic [OCC_W-1:0]      res_occ_q;
	logic                  res_none_q;
	logic                  res_ovf_q;
	logic                  res_last_q;

	logic [TABLE_ENTRIES-1:0] hit;
	logic                  hit_any;
	logic                  table_full;
	logic [KW-1:0]         top_k_ext;
	logic [KW-1:0]         used_ext;
	logic [TOPK_W-1:0]     k_lim;
	logic                  take;
	logic                  clear_table;
	logic [USED_W-1:0]     scan_next;

	// parallel match against every stored value
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit[i] = entry_valid_q[i] && entry_value_q[i] == VALUE_W'(in_value);
		end
	end

	assign hit_any    = |hit;
	assign table_full = used_q == USED_W'(TABLE_ENTRIES);

	assign top_k_ext = KW'(in_top_k);
	assign used_ext  = KW'(used_q);
	assign k_lim     = (top_k_ext > used_ext) ? TOPK_W'(used_q) : in_top_k;

	assign take = !reported_q[scan_idx_q] &&
		(best_none_q || entry_count_q[scan_idx_q] > best_cnt_q);

	assign scan_next   = USED_W'(scan_idx_q) + USED_W'(1);
	assign clear_table = cmd.emit_none || (cmd.emit && k_left_q == TOPK_W'(1));

	assign sts.k_zero     = k_lim == '0;
	assign sts.scan_last  = scan_next == used_q;
	assign sts.out_free   = !res_valid_q || results.ready;
	assign sts.final_pick = k_left_q == TOPK_W'(1);

	// payload stores, no reset: only read behind a valid bit
	always_ff @(posedge clk) begin
		if (cmd.add) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (hit[i] && entry_count_q[i] != '1) begin
					entry_count_q[i] <= entry_count_q[i] + COUNT_BITS'(1);
				end
			end
			if (!hit_any && !table_full) begin
				entry_value_q[used_q[IDX_W-1:0]] <= VALUE_W'(in_value);
				entry_count_q[used_q[IDX_W-1:0]] <= COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			reported_q    <= '0;
			used_q        <= '0;
			overflow_q    <= 1'b0;
		end else if (clear_table) begin
			entry_valid_q <= '0;
			reported_q    <= '0;
			used_q        <= '0;
			overflow_q    <= 1'b0;
		end else begin
			if (cmd.add && !hit_any) begin
				if (table_full) begin
					overflow_q <= 1'b1;
				end else begin
					entry_valid_q[used_q[IDX_W-1:0]] <= 1'b1;
					used_q <= used_q + USED_W'(1);
				end
			end
			if (cmd.emit) begin
				reported_q[best_idx_q] <= 1'b1;
			end
		end
	end

	// scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			best_none_q <= 1'b1;
			k_left_q    <= '0;
		end else begin
			if (cmd.start) begin
				k_left_q    <= k_lim;
				scan_idx_q  <= '0;
				best_none_q <= 1'b1;
			end
			if (cmd.step) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (take) begin
					best_none_q <= 1'b0;
				end
			end
			if (cmd.emit) begin
				k_left_q    <= k_left_q - TOPK_W'(1);
				scan_idx_q  <= '0;
				best_none_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && take) begin
			best_idx_q   <= scan_idx_q;
			best_value_q <= entry_value_q[scan_idx_q];
			best_cnt_q   <= entry_count_q[scan_idx_q];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_none) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_value_q <= best_value_q;
			res_occ_q   <= OCC_W'(best_cnt_q);
			res_none_q  <= 1'b0;
			res_ovf_q   <= overflow_q;
			res_last_q  <= k_left_q == TOPK_W'(1);
		end else if (cmd.emit_none) begin
			res_value_q <= '0;
			res_occ_q   <= '0;
			res_none_q  <= 1'b1;
			res_ovf_q   <= overflow_q;
			res_last_q  <= 1'b1;
		end
	end

	assign results.valid            = res_valid_q;
	assign results.frequent_value   = $signed(res_value_q);
	assign results.occurrences      = res_occ_q;
	assign results.no_item          = res_none_q;
	assign results.table_overflowed = res_ovf_q;
	assign results.last_result      = res_last_q;

endmodule
